// ===== rtl/core/mmpd_pkg.sv =====
// ---------------------------------------------------------------------------
// mmpd_pkg
// shared types and constants of the min/max peak decimator
// ---------------------------------------------------------------------------
package mmpd_pkg;

  // fixed field widths
  localparam int CNT_W      = 17;
  localparam int BIN_LEN_W  = 16;
  localparam int RING_LEN_W = 13;
  localparam int GAIN_W     = 16;
  localparam int MARGIN_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_BIN_LENGTH  = 3'd1,
    REG_RING_LENGTH = 3'd2,
    REG_DB_CUT      = 3'd3,
    REG_CUT_GAIN    = 3'd4,
    REG_MARGIN      = 3'd5
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [BIN_LEN_W-1:0]  BIN_LENGTH_RST  = 16'd256;
  localparam logic [RING_LEN_W-1:0] RING_LENGTH_RST = 13'd1024;
  localparam logic [GAIN_W-1:0]     CUT_GAIN_RST    = 16'd58409;
  localparam logic [MARGIN_W-1:0]   MARGIN_RST      = 10'd66;

  // saturation limit of the bin counter
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register set
  typedef struct packed {
    logic                  enable;
    logic [BIN_LEN_W-1:0]  bin_length;
    logic [RING_LEN_W-1:0] ring_length;
    logic                  db_cut;
    logic [GAIN_W-1:0]     cut_gain;
    logic [MARGIN_W-1:0]   margin;
  } cfg_t;

endpackage

// ===== rtl/core/mmpd_if.sv =====
// ---------------------------------------------------------------------------
// mmpd_if
// valid/ready channels of the min/max peak decimator
// ---------------------------------------------------------------------------

// sample channel
interface mmpd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// min/max pair channel
interface mmpd_out_if #(
  parameter int SLOT_W      = 12,
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [SLOT_W-1:0]             slot;
  logic signed [SAMPLE_BITS-1:0] peak_max;
  logic signed [SAMPLE_BITS-1:0] peak_min;

  modport source (output valid, output slot, output peak_max, output peak_min, input ready);
  modport sink   (input valid, input slot, input peak_max, input peak_min, output ready);
endinterface

// ===== rtl/core/mmpd_peak_fmt.sv =====
// ---------------------------------------------------------------------------
// mmpd_peak_fmt
// optional gain cut, margin and saturation of one bin extreme
// ---------------------------------------------------------------------------
module mmpd_peak_fmt #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0]      extreme,
  input  logic                               cut_en,
  input  logic [mmpd_pkg::GAIN_W-1:0]        cut_gain,
  input  logic [mmpd_pkg::MARGIN_W-1:0]      margin,
  input  logic                               sub_margin,
  output logic signed [SAMPLE_BITS-1:0]      peak
);

  localparam int PROD_W = SAMPLE_BITS + mmpd_pkg::GAIN_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + mmpd_pkg::MARGIN_W + 1;

  localparam logic [SAMPLE_BITS-1:0] PEAK_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] PEAK_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] scaled;
  logic signed [SAMPLE_BITS-1:0] sel;
  logic [SUM_W-1:0]              sel_ext;
  logic [SUM_W-1:0]              marg_ext;
  logic [SUM_W-1:0]              sum;
  logic [SUM_W-SAMPLE_BITS:0]    upper;

  // gain cut: drop the low 16 bits of the exact product (floor)
  assign prod   = extreme * $signed({1'b0, cut_gain});
  assign scaled = prod[SAMPLE_BITS+mmpd_pkg::GAIN_W-1:mmpd_pkg::GAIN_W];
  assign sel    = cut_en ? scaled : extreme;

  // margin applied at full width
  assign sel_ext  = {{(SUM_W-SAMPLE_BITS){sel[SAMPLE_BITS-1]}}, sel};
  assign marg_ext = {{(SUM_W-mmpd_pkg::MARGIN_W){1'b0}}, margin};
  assign sum      = sub_margin ? (sel_ext - marg_ext) : (sel_ext + marg_ext);

  // saturate when the bits above the sample sign disagree
  assign upper = sum[SUM_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((upper == '0) || (upper == '1)) begin
      peak = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      peak = PEAK_MIN;
    end else begin
      peak = PEAK_MAX;
    end
  end

endmodule

// ===== rtl/core/minmax_peak_decimator.sv =====
// ---------------------------------------------------------------------------
// minmax_peak_decimator
// min/max envelope decimator for a signed audio sample stream
// ---------------------------------------------------------------------------
// Samples arrive on in_ch (valid/ready) and are folded into a running maximum
// and minimum. Once the bin counter has reached bin_length a min/max pair is
// sent on out_ch together with its ring slot; the slot wraps at ring_length
// (or MAX_RING if smaller). The first bin holds one sample more than the rest.
// Registers are written through cfg_we/cfg_index/cfg_data, by the user only
// while the block is idle; the block does not enforce it. With enable low,
// transfers on in_ch are taken and dropped. A sample passes through the input
// register and, when it closes a bin, the result register to reach out_ch.
// Throughput: one sample per cycle while out_ch does not stall, as the
// extremes, the bin counter and the result register update together.
// When out_ch stalls with a pair pending, the input register still takes a
// sample if empty, then in_ch.ready drops until the pair is transferred. Reset
// (rst_n low, synchronous) restores the configuration defaults, sets the
// extremes to opposite limits, clears counter and slot, empties both registers.
// ---------------------------------------------------------------------------
module minmax_peak_decimator #(
  parameter int MAX_RING    = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  mmpd_in_if.sink                             in_ch,
  mmpd_out_if.source                          out_ch
);

  localparam int SLOT_W = $clog2(MAX_RING);
  localparam int LIM_W  = (SLOT_W + 1 > mmpd_pkg::RING_LEN_W) ? SLOT_W + 1
                                                               : mmpd_pkg::RING_LEN_W;
  localparam logic [LIM_W-1:0] RING_CAP = LIM_W'(MAX_RING);

  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  mmpd_pkg::cfg_t                   cfg_r;

  logic                             s1_vld_r;
  logic signed [SAMPLE_BITS-1:0]    s1_smp_r;

  logic signed [SAMPLE_BITS-1:0]    run_max_r, run_max_nxt;
  logic signed [SAMPLE_BITS-1:0]    run_min_r, run_min_nxt;
  logic [mmpd_pkg::CNT_W-1:0]       bin_cnt_r, bin_cnt_nxt;
  logic [SLOT_W-1:0]                slot_r, slot_nxt;

  logic                             out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0]                out_slot_r;
  logic signed [SAMPLE_BITS-1:0]    out_max_r;
  logic signed [SAMPLE_BITS-1:0]    out_min_r;

  logic                             advance;
  logic                             work;
  logic                             hit;
  logic signed [SAMPLE_BITS-1:0]    bin_max;
  logic signed [SAMPLE_BITS-1:0]    bin_min;
  logic [mmpd_pkg::CNT_W-1:0]       cnt_left;
  logic [mmpd_pkg::CNT_W-1:0]       bin_len_ext;
  logic [LIM_W-1:0]                 ring_ext;
  logic [LIM_W-1:0]                 ring_lim;
  logic [LIM_W-1:0]                 slot_inc;
  logic signed [SAMPLE_BITS-1:0]    peak_max;
  logic signed [SAMPLE_BITS-1:0]    peak_min;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.bin_length  <= mmpd_pkg::BIN_LENGTH_RST;
      cfg_r.ring_length <= mmpd_pkg::RING_LENGTH_RST;
      cfg_r.db_cut      <= 1'b0;
      cfg_r.cut_gain    <= mmpd_pkg::CUT_GAIN_RST;
      cfg_r.margin      <= mmpd_pkg::MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmpd_pkg::REG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        mmpd_pkg::REG_BIN_LENGTH:  cfg_r.bin_length  <= cfg_data[mmpd_pkg::BIN_LEN_W-1:0];
        mmpd_pkg::REG_RING_LENGTH: cfg_r.ring_length <= cfg_data[mmpd_pkg::RING_LEN_W-1:0];
        mmpd_pkg::REG_DB_CUT:      cfg_r.db_cut      <= cfg_data[0];
        mmpd_pkg::REG_CUT_GAIN:    cfg_r.cut_gain    <= cfg_data[mmpd_pkg::GAIN_W-1:0];
        mmpd_pkg::REG_MARGIN:      cfg_r.margin      <= cfg_data[mmpd_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register can take it
  assign advance     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || advance;
  assign work        = advance && cfg_r.enable;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_smp_r <= in_ch.sample;
    end
  end

  // fold the sample into the running extremes
  assign bin_max = (s1_smp_r > run_max_r) ? s1_smp_r : run_max_r;
  assign bin_min = (s1_smp_r < run_min_r) ? s1_smp_r : run_min_r;

  // bin counter check before it advances
  assign bin_len_ext = {{(mmpd_pkg::CNT_W-mmpd_pkg::BIN_LEN_W){1'b0}}, cfg_r.bin_length};
  assign hit         = (bin_cnt_r >= bin_len_ext);
  assign cnt_left    = hit ? (bin_cnt_r - bin_len_ext) : bin_cnt_r;

  // ring slot wrap
  assign ring_ext = LIM_W'(cfg_r.ring_length);
  assign ring_lim = (ring_ext > RING_CAP) ? RING_CAP : ring_ext;
  assign slot_inc = LIM_W'(slot_r) + LIM_W'(1);

  // scaled, margined and saturated extremes
  mmpd_peak_fmt #(.SAMPLE_BITS(SAMPLE_BITS)) u_fmt_max (
    .extreme    (bin_max),
    .cut_en     (cfg_r.db_cut),
    .cut_gain   (cfg_r.cut_gain),
    .margin     (cfg_r.margin),
    .sub_margin (1'b0),
    .peak       (peak_max)
  );

  mmpd_peak_fmt #(.SAMPLE_BITS(SAMPLE_BITS)) u_fmt_min (
    .extreme    (bin_min),
    .cut_en     (cfg_r.db_cut),
    .cut_gain   (cfg_r.cut_gain),
    .margin     (cfg_r.margin),
    .sub_margin (1'b1),
    .peak       (peak_min)
  );

  // next state of the bin
  always_comb begin
    run_max_nxt = run_max_r;
    run_min_nxt = run_min_r;
    bin_cnt_nxt = bin_cnt_r;
    slot_nxt    = slot_r;
    if (work) begin
      run_max_nxt = hit ? SMP_MIN : bin_max;
      run_min_nxt = hit ? SMP_MAX : bin_min;
      bin_cnt_nxt = (cnt_left == mmpd_pkg::CNT_MAX) ? cnt_left
                                                    : cnt_left + mmpd_pkg::CNT_W'(1);
      if (hit) begin
        slot_nxt = (slot_inc >= ring_lim) ? '0 : slot_inc[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r <= SMP_MIN;
      run_min_r <= SMP_MAX;
      bin_cnt_r <= '0;
      slot_r    <= '0;
    end else begin
      run_max_r <= run_max_nxt;
      run_min_r <= run_min_nxt;
      bin_cnt_r <= bin_cnt_nxt;
      slot_r    <= slot_nxt;
    end
  end

  // result register
  always_comb begin
    if (work && hit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (work && hit) begin
      out_slot_r <= slot_r;
      out_max_r  <= peak_max;
      out_min_r  <= peak_min;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.slot     = out_slot_r;
  assign out_ch.peak_max = out_max_r;
  assign out_ch.peak_min = out_min_r;

endmodule
